>>> hdl/cle_pkg.sv
// Package for the console line editor: sizes, key codes, item and control types.
package cle_pkg;

  // Ring size (a power of two) and derived widths
  localparam int unsigned DEPTH  = 128;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PTR_W  = ADDR_W + 1;

  // Control keys
  localparam logic [7:0] KEY_DUMP = 8'h10;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_DEL  = 8'h7F;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_NUL  = 8'h00;

  // Request kinds
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_char;
    logic       first_of_read;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       wake;
    logic       dump_request;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_eof;
    logic       read_line_end;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_HOLD
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec_char;
    logic rd_en;
    logic exec_read;
    logic exec_empty;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic has_data;
  } status_t;

endpackage

>>> hdl/cle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cle_datapath.sv
// Datapath of the console line editor: pointers, line ring and result register.
module cle_datapath import cle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_item_i,
  output status_t   status_o,
  output out_item_t out_item_o
);

  localparam logic [PTR_W-1:0] DepthPtr = PTR_W'(DEPTH);
  localparam logic [PTR_W-1:0] OnePtr   = PTR_W'(1);

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] cm_ptr_q, cm_ptr_d;
  logic [PTR_W-1:0] ed_ptr_q, ed_ptr_d;
  in_item_t         item_q;
  out_item_t        res_q, res_d;

  logic [PTR_W-1:0]   fill;
  logic [PTR_W-1:0]   fill_next;
  logic [PTR_W-1:0]   span;
  logic [PTR_W+7:0]   span_w;
  logic [7:0]         span_sat;
  logic [7:0]         ch_map;
  logic               we;
  logic [7:0]         rdata;

  // Pointer differences, modulo twice the ring size
  assign fill      = ed_ptr_q - rd_ptr_q;
  assign fill_next = fill + OnePtr;
  assign span      = ed_ptr_q - cm_ptr_q;
  assign span_w    = {8'd0, span};
  assign span_sat  = (span_w > (PTR_W + 8)'(255)) ? 8'hFF : span_w[7:0];
  assign ch_map    = (item_q.rx_char == KEY_CR) ? KEY_LF : item_q.rx_char;

  assign status_o.is_read  = (item_q.req_type == REQ_READ);
  assign status_o.has_data = (rd_ptr_q != cm_ptr_q);

  // Execute the held item
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    cm_ptr_d = cm_ptr_q;
    ed_ptr_d = ed_ptr_q;
    res_d    = res_q;
    we       = 1'b0;
    if (cmd_i.exec_char) begin
      res_d = '0;
      priority if (item_q.rx_char == KEY_DUMP) begin
        res_d.dump_request = 1'b1;
      end else if (item_q.rx_char == KEY_KILL) begin
        ed_ptr_d          = cm_ptr_q;
        res_d.erase_count = span_sat;
      end else if (item_q.rx_char == KEY_BS || item_q.rx_char == KEY_DEL) begin
        if (ed_ptr_q != cm_ptr_q) begin
          ed_ptr_d          = ed_ptr_q - OnePtr;
          res_d.erase_count = 8'd1;
        end
      end else if (item_q.rx_char != KEY_NUL && !fill[PTR_W-1]) begin
        we               = 1'b1;
        res_d.echo_valid = 1'b1;
        res_d.echo_char  = ch_map;
        ed_ptr_d         = ed_ptr_q + OnePtr;
        if (ch_map == KEY_LF || ch_map == KEY_EOF || fill_next == DepthPtr) begin
          cm_ptr_d   = ed_ptr_q + OnePtr;
          res_d.wake = 1'b1;
        end
      end else begin
        res_d = '0;
      end
    end else if (cmd_i.exec_read) begin
      res_d            = '0;
      res_d.read_valid = 1'b1;
      res_d.read_char  = rdata;
      if (rdata == KEY_EOF) begin
        res_d.read_eof = 1'b1;
        if (item_q.first_of_read) begin
          rd_ptr_d = rd_ptr_q + OnePtr;
        end
      end else begin
        rd_ptr_d            = rd_ptr_q + OnePtr;
        res_d.read_line_end = (rdata == KEY_LF);
      end
    end else if (cmd_i.exec_empty) begin
      res_d = '0;
    end
  end

  // Pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      cm_ptr_q <= '0;
      ed_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      cm_ptr_q <= cm_ptr_d;
      ed_ptr_q <= ed_ptr_d;
    end
  end

  // Item and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    res_q <= res_d;
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ed_ptr_q[ADDR_W-1:0]),
    .wdata_i (ch_map),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_ptr_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign out_item_o = res_q;

  // Ring never holds more than its size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ed_ptr_q - rd_ptr_q) <= DepthPtr)
    else $error("ring fill exceeds depth");

  // Commit point lies between read and edit points
  a_commit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cm_ptr_q - rd_ptr_q) <= (ed_ptr_q - rd_ptr_q))
    else $error("commit pointer outside read..edit span");

  // Ring read data is consumed the cycle after it is fetched
  a_read_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |=> cmd_i.exec_read)
    else $error("ring read not followed by read execution");

endmodule

>>> hdl/cle_ctrl.sv
// Controller state machine of the console line editor.
module cle_ctrl import cle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_read && status_i.has_data) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_READ: state_d = ST_HOLD;
      ST_HOLD: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.exec_char  = !status_i.is_read;
        cmd_o.rd_en      = status_i.is_read && status_i.has_data;
        cmd_o.exec_empty = status_i.is_read && !status_i.has_data;
      end
      ST_READ: cmd_o.exec_read = 1'b1;
      ST_HOLD: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/console_line_editor_top.sv
// Top level of the console line editor: controller, datapath and ring.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) carries either a
// received character or a request to read one committed byte. Output
// channel (out_valid_o / out_stall_i / out_item_o) returns exactly one
// result item per input item, in order.
// One item is worked at a time. A received character passes through the
// decode and hold states; a read that finds committed data also passes
// through the read state, for the registered read of the line ring. The
// result item is registered and valid on the output in the hold state;
// once it is taken, the block returns to idle and accepts the next item.
// While the receiver stalls, the result item holds steady on the output and
// in_stall_o stays high; nothing is dropped.
// Reset (rst_ni low, asynchronous) clears the read, commit and edit
// pointers and returns the controller to idle. The ring contents are not
// cleared; entries are only read after they were written.
module console_line_editor_top import cle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t    cmd;
  status_t status;

  cle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cle_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule
